// ----- rtl/lfrs_pkg.sv -----
// lfrs_pkg: shared types and constants for the loss feedback rate scaler.
// Used by lfrs_update and loss_feedback_rate_scaler_unit; no dependencies.
package lfrs_pkg;

  // action codes
  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_TIMER = 1'b1;

  // floor(t/5) = (t * RECIP5) >> 34, exact for any 32-bit t
  localparam logic [31:0] RECIP5       = 32'hCCCC_CCCD;
  localparam int unsigned RECIP5_SHIFT = 34;
  // 2^32 = 5 * DIV5_OF_2P32 + 1
  localparam logic [31:0] DIV5_OF_2P32 = 32'd858993459;

  localparam logic [32:0] PREV_SEQ_RESET = {33{1'b1}};  // minus one
  localparam logic [32:0] LOST_MAX       = 33'h0_FFFF_FFFF;
  localparam logic [32:0] LOST_MIN       = 33'h1_0000_0000;

  typedef struct packed {
    logic [32:0] prev_seq;  // two's complement, minus one after restart
    logic [32:0] lost;      // two's complement, saturating
    logic        recv;      // at least one packet since the last ack
    logic [2:0]  level;
    logic [31:0] rtt;       // smoothed round trip, microseconds
  } state_t;

endpackage

// ----- rtl/lfrs_update.sv -----
// lfrs_update: next-state and ack logic for one item, purely combinational.
// Depends on lfrs_pkg (state_t, division constants, action codes).
module lfrs_update #(
  parameter int MAX_LEVEL = 4,
  parameter int TIME_BITS = 32
) (
  input  logic            action_i,
  input  logic [31:0]     seq_i,
  input  logic [31:0]     send_time_i,
  input  logic [31:0]     local_time_i,
  input  lfrs_pkg::state_t state_i,
  output lfrs_pkg::state_t state_o,
  output logic            emit_o,
  output logic [2:0]      ack_level_o,
  output logic [31:0]     ack_time_o,
  output logic [31:0]     next_ack_delay_o
);
  import lfrs_pkg::*;

  localparam int          MaskBits = (TIME_BITS >= 32) ? 32 : TIME_BITS;
  localparam logic [31:0] TimeMask = {32{1'b1}} >> (32 - MaskBits);
  localparam logic [2:0]  LevelCap = (MAX_LEVEL > 7) ? 3'd7 : 3'(MAX_LEVEL);

  logic [31:0] st;
  logic [31:0] now;
  logic [32:0] diff;
  logic [31:0] delay;
  logic [32:0] seed;
  logic [31:0] seed_sat;
  logic [35:0] acc;
  logic [34:0] half;
  logic [2:0]  hi;
  logic [32:0] fold;
  logic [31:0] tail;
  logic [63:0] prod;
  logic [29:0] tail_div5;
  logic [3:0]  k;
  logic [33:0] quot;
  logic [31:0] quot_sat;
  logic        seq_zero;
  logic [32:0] lost_base;
  logic [32:0] prev_base;
  logic [34:0] nl;
  logic [32:0] lost_new;
  state_t      acc_state;
  logic [2:0]  lvl_in;
  logic [2:0]  lvl_adj;

  assign st   = send_time_i & TimeMask;
  assign now  = local_time_i & TimeMask;
  assign diff = {1'b0, now} - {1'b0, st};
  assign delay = diff[32] ? 32'd0 : diff[31:0];

  // seed: twice the delay, saturated
  assign seed     = {delay, 1'b0};
  assign seed_sat = seed[32] ? {32{1'b1}} : seed[31:0];

  // (9*rtt + 2*delay) / 10 = floor(acc/2) / 5, folded on 2^32 = 1 mod 5
  assign acc  = {1'b0, state_i.rtt, 3'b000} + {4'b0000, state_i.rtt} + {3'b000, delay, 1'b0};
  assign half = acc[35:1];
  assign hi   = half[34:32];
  assign fold = {1'b0, half[31:0]} + {30'd0, hi};
  // fold[32] set only when the low word is tiny, so this cannot carry out
  assign tail = fold[31:0] + {31'd0, fold[32]};
  assign prod = 64'(tail) * 64'(RECIP5);
  assign tail_div5 = prod[63:RECIP5_SHIFT];
  assign k    = {1'b0, hi} + {3'b000, fold[32]};
  assign quot = 34'(k) * 34'(DIV5_OF_2P32) + 34'(tail_div5);
  assign quot_sat = (quot[33:32] != 2'b00) ? {32{1'b1}} : quot[31:0];

  // loss accounting, restarted by sequence zero
  assign seq_zero  = (seq_i == 32'd0);
  assign lost_base = seq_zero ? 33'd0 : state_i.lost;
  assign prev_base = seq_zero ? PREV_SEQ_RESET : state_i.prev_seq;
  assign nl = {{2{lost_base[32]}}, lost_base} + {3'b000, seq_i}
            - {{2{prev_base[32]}}, prev_base} - 35'd1;

  always_comb begin
    if (nl[34:32] == 3'b000 || nl[34:32] == 3'b111) begin
      lost_new = nl[32:0];
    end else if (nl[34]) begin
      lost_new = LOST_MIN;
    end else begin
      lost_new = LOST_MAX;
    end
  end

  // state after the packet accounting, before any level adjustment
  always_comb begin
    acc_state = state_i;
    if (action_i == ACT_DATA) begin
      acc_state.prev_seq = {1'b0, seq_i};
      acc_state.lost     = lost_new;
      acc_state.recv     = 1'b1;
      acc_state.rtt      = seq_zero ? seed_sat : quot_sat;
      if (seq_zero) begin
        acc_state.level = 3'd0;
      end
    end
  end

  // aimd step: halve on loss, else step up to the cap, hold if nothing came
  assign lvl_in = acc_state.level;
  always_comb begin
    lvl_adj = lvl_in;
    if (acc_state.recv) begin
      if (!acc_state.lost[32] && acc_state.lost != 33'd0) begin
        lvl_adj = {1'b0, lvl_in[2:1]};
      end else if (lvl_in >= LevelCap) begin
        lvl_adj = LevelCap;
      end else begin
        lvl_adj = lvl_in + 3'd1;
      end
    end
  end

  assign emit_o = (action_i == ACT_TIMER) || seq_zero;

  always_comb begin
    state_o = acc_state;
    if (emit_o) begin
      state_o.level = lvl_adj;
      state_o.recv  = 1'b0;
      state_o.lost  = 33'd0;
    end
  end

  assign ack_level_o      = lvl_adj;
  assign ack_time_o       = now;
  assign next_ack_delay_o = acc_state.rtt;

endmodule

// ----- rtl/loss_feedback_rate_scaler_unit.sv -----
// loss_feedback_rate_scaler_unit: receiver-side aimd rate feedback top level.
// Depends on lfrs_pkg and lfrs_update.
//
//   channel | valid / ready           | payload
//   --------+-------------------------+---------------------------------------
//   in      | in_valid_i / in_ready_o | action_i seq_i send_time_i local_time_i
//   out     | out_valid_o/ out_ready_i| ack_level_o ack_time_o next_ack_delay_o
//
// One item per cycle sustained while the result register is drained; an ack
// passes from its item through the input register, then the result register.
// The state update and the rtt divide-by-ten (one 32x32 reciprocal multiply)
// sit between the input register and the result register.
// An item in the input register that makes an ack waits while the result
// register is full and not being drained; items without an ack never wait.
// Reset restores last sequence minus one, counters, level and rtt to zero.
module loss_feedback_rate_scaler_unit #(
  parameter int MAX_LEVEL = 4,
  parameter int TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] seq_i,
  input  logic [31:0] send_time_i,
  input  logic [31:0] local_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  ack_level_o,
  output logic [31:0] ack_time_o,
  output logic [31:0] next_ack_delay_o
);
  import lfrs_pkg::*;

  logic        in_valid_q;
  logic        action_q;
  logic [31:0] seq_q;
  logic [31:0] send_time_q;
  logic [31:0] local_time_q;

  state_t      state_q;
  state_t      state_d;

  logic        emit;
  logic [2:0]  ack_level_d;
  logic [31:0] ack_time_d;
  logic [31:0] next_ack_delay_d;

  logic        out_valid_q;
  logic [2:0]  ack_level_q;
  logic [31:0] ack_time_q;
  logic [31:0] next_ack_delay_q;

  logic        out_free;
  logic        advance;
  logic        in_fire;

  lfrs_update #(
    .MAX_LEVEL(MAX_LEVEL),
    .TIME_BITS(TIME_BITS)
  ) u_update (
    .action_i        (action_q),
    .seq_i           (seq_q),
    .send_time_i     (send_time_q),
    .local_time_i    (local_time_q),
    .state_i         (state_q),
    .state_o         (state_d),
    .emit_o          (emit),
    .ack_level_o     (ack_level_d),
    .ack_time_o      (ack_time_d),
    .next_ack_delay_o(next_ack_delay_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!emit || out_free);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      state_q.prev_seq  <= PREV_SEQ_RESET;
      state_q.lost      <= 33'd0;
      state_q.recv      <= 1'b0;
      state_q.level     <= 3'd0;
      state_q.rtt       <= 32'd0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q     <= action_i;
      seq_q        <= seq_i;
      send_time_q  <= send_time_i;
      local_time_q <= local_time_i;
    end
    if (advance && emit) begin
      ack_level_q      <= ack_level_d;
      ack_time_q       <= ack_time_d;
      next_ack_delay_q <= next_ack_delay_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ack_level_o      = ack_level_q;
  assign ack_time_o       = ack_time_q;
  assign next_ack_delay_o = next_ack_delay_q;

endmodule

// ----- sim/tb_loss_feedback_rate_scaler_unit.sv -----
// tb_loss_feedback_rate_scaler_unit: self-checking bench for the aimd rate feedback unit.
// Runs a directed table, then random packet and timer traffic checked against an in-bench
// ack predictor. Depends on lfrs_pkg and loss_feedback_rate_scaler_unit.
`timescale 1ns / 100ps

module tb_loss_feedback_rate_scaler_unit;
  import lfrs_pkg::*;

  localparam int MAX_LEVEL    = 4;
  localparam int LEVEL_CAP    = (MAX_LEVEL > 7) ? 7 : MAX_LEVEL;
  localparam int RANDOM_ITEMS = 850;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_OFF     = 400;
  localparam int MAX_PRINTS   = 60;
  localparam longint LOST_CEIL  = 64'sd4294967295;
  localparam longint LOST_FLOOR = -64'sd4294967296;

  typedef struct packed {
    logic [2:0]  level;
    logic [31:0] stamp;
    logic [31:0] delay;
  } ack_t;

  typedef struct {
    logic        act;
    logic [31:0] sq;
    logic [31:0] st;
    logic [31:0] lt;
    bit          typed;
    ack_t        ack;
  } row_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic        action_i     = ACT_DATA;
  logic [31:0] seq_i        = '0;
  logic [31:0] send_time_i  = '0;
  logic [31:0] local_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [2:0]  ack_level_o;
  logic [31:0] ack_time_o;
  logic [31:0] next_ack_delay_o;

  // predictor state, reset values
  logic signed [32:0] prev_seq_q = -1;
  logic signed [32:0] lost_q     = '0;
  logic [31:0]        rcv_q      = '0;
  logic [2:0]         lvl_q      = '0;
  logic [31:0]        rtt_q      = '0;

  ack_t pending_acks[$];
  int   errors     = 0;
  int   acks_seen  = 0;
  int   idle_count = 0;

  // directed sequence: reset, wrap gaps, clamped delays, level cap, lost clamp
  row_t directed_rows[] = '{
    '{ACT_TIMER, 32'd0,          32'd0,          32'h0000_1234, 1'b1,
      '{3'd0, 32'h0000_1234, 32'd0}},
    '{ACT_DATA,  32'hFFFF_FFFF,  32'd0,          32'd10,        1'b0, '0},
    '{ACT_TIMER, 32'd0,          32'd0,          32'd20,        1'b0, '0},
    '{ACT_DATA,  32'd0,          32'd100,        32'd150,       1'b1,
      '{3'd1, 32'd150, 32'd100}},
    '{ACT_DATA,  32'd1,          32'd200,        32'd260,       1'b0, '0},
    '{ACT_TIMER, 32'd0,          32'd0,          32'd400,       1'b0, '0},
    '{ACT_DATA,  32'd5,          32'd410,        32'd500,       1'b0, '0},
    '{ACT_TIMER, 32'd0,          32'd0,          32'd600,       1'b0, '0},
    '{ACT_DATA,  32'd0,          32'hFFFF_FFFF,  32'd0,         1'b1,
      '{3'd1, 32'd0, 32'd0}},
    '{ACT_DATA,  32'd0,          32'd0,          32'hFFFF_FFFF, 1'b1,
      '{3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{ACT_DATA,  32'd1,          32'd0,          32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_TIMER, 32'd0,          32'd0,          32'd5,         1'b0, '0},
    '{ACT_DATA,  32'd2,          32'd6,          32'd70,        1'b0, '0},
    '{ACT_TIMER, 32'd0,          32'd0,          32'd80,        1'b0, '0},
    '{ACT_DATA,  32'd3,          32'd90,         32'd95,        1'b0, '0},
    '{ACT_TIMER, 32'd0,          32'd0,          32'd99,        1'b0, '0},
    '{ACT_DATA,  32'd3,          32'd100,        32'd130,       1'b0, '0},
    '{ACT_DATA,  32'd2,          32'd110,        32'd140,       1'b0, '0},
    '{ACT_TIMER, 32'd0,          32'd0,          32'd150,       1'b0, '0},
    '{ACT_DATA,  32'hFFFF_FFFF,  32'd160,        32'd170,       1'b0, '0},
    '{ACT_TIMER, 32'd0,          32'd0,          32'd180,       1'b0, '0},
    '{ACT_DATA,  32'd1,          32'd190,        32'd200,       1'b0, '0},
    '{ACT_DATA,  32'd1,          32'd210,        32'd220,       1'b0, '0},
    '{ACT_DATA,  32'd1,          32'd230,        32'd240,       1'b0, '0},
    '{ACT_TIMER, 32'd0,          32'd0,          32'd250,       1'b0, '0}
  };

  loss_feedback_rate_scaler_unit #(
    .MAX_LEVEL(MAX_LEVEL),
    .TIME_BITS(32)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .seq_i           (seq_i),
    .send_time_i     (send_time_i),
    .local_time_i    (local_time_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ack_level_o     (ack_level_o),
    .ack_time_o      (ack_time_o),
    .next_ack_delay_o(next_ack_delay_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // aimd step at ack time, then the loss window restarts
  function automatic void settle_level();
    if (rcv_q != 0) begin
      if (lost_q > 0) lvl_q = lvl_q >> 1;
      else if (lvl_q < LEVEL_CAP) lvl_q = lvl_q + 3'd1;
    end
    rcv_q  = '0;
    lost_q = '0;
  endfunction

  function automatic bit predict_ack(input logic act, input logic [31:0] sq, st, lt,
                                     output ack_t ack);
    longint dly;
    longint acc;
    longint nl;
    ack = '0;
    if (act == ACT_TIMER) begin
      settle_level();
      ack = '{lvl_q, lt, rtt_q};
      return 1'b1;
    end
    dly = (lt > st) ? longint'({32'd0, lt}) - longint'({32'd0, st}) : 64'sd0;
    if (sq == 0) begin
      prev_seq_q = -1;
      lvl_q      = '0;
      lost_q     = '0;
      rcv_q      = '0;
      acc        = 2 * dly;
    end else begin
      acc = (9 * longint'({32'd0, rtt_q}) + 2 * dly) / 10;
    end
    rtt_q = (acc > LOST_CEIL) ? '1 : acc[31:0];
    if (rcv_q != '1) rcv_q = rcv_q + 32'd1;
    // negative gap from reordered or duplicate packets pulls the loss count down
    nl = longint'(lost_q) + longint'({32'd0, sq}) - longint'(prev_seq_q) - 1;
    if (nl > LOST_CEIL) nl = LOST_CEIL;
    if (nl < LOST_FLOOR) nl = LOST_FLOOR;
    lost_q     = nl[32:0];
    prev_seq_q = {1'b0, sq};
    if (sq == 0) begin
      settle_level();
      ack = '{lvl_q, lt, rtt_q};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want, got);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t: %s expected %h got %h", $time, what, want, got);
  endtask

  task automatic send_item(input logic act, input logic [31:0] sq, st, lt, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    seq_i        <= sq;
    send_time_i  <= st;
    local_time_i <= lt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic apply_item(input logic act, input logic [31:0] sq, st, lt, input int gap,
                            input bit typed, input ack_t typed_ack);
    ack_t ack;
    send_item(act, sq, st, lt, gap);
    if (predict_ack(act, sq, st, lt, ack))
      pending_acks.push_back(typed ? typed_ack : ack);
  endtask

  // result side: random stalls, free-running stretches, one long hold-off
  initial begin
    int  hold;
    int  cyc;
    bit  held_off;
    hold     = 0;
    cyc      = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else if (!held_off && acks_seen >= 60) begin
        // let the block fill up and push back on its input
        held_off = 1'b1;
        hold     = HOLD_OFF - 1;
        out_ready_i <= 1'b0;
      end else if ((cyc / 500) % 4 == 3) begin
        out_ready_i <= 1'b1;
      end else begin
        hold = gap_len();
        if (hold > 0) begin
          out_ready_i <= 1'b0;
          hold--;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    ack_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      acks_seen++;
      if (pending_acks.size() == 0) begin
        report_mismatch("ack with nothing pending, level", '0, {29'd0, ack_level_o});
      end else begin
        want = pending_acks.pop_front();
        if (ack_level_o !== want.level)
          report_mismatch("ack_level", {29'd0, want.level}, {29'd0, ack_level_o});
        if (ack_time_o !== want.stamp)
          report_mismatch("ack_time", want.stamp, ack_time_o);
        if (next_ack_delay_o !== want.delay)
          report_mismatch("next_ack_delay", want.delay, next_ack_delay_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_count <= 0;
    else idle_count <= idle_count + 1;
  end

  initial begin
    while (idle_count < IDLE_LIMIT) @(posedge clk_i);
    $display("loss_feedback_rate_scaler_unit: mismatch");
    $finish;
  end

  initial begin
    int          pick;
    logic        act;
    logic [31:0] sq;
    logic [31:0] st;
    logic [31:0] lt;
    logic [31:0] next_seq;
    logic [31:0] clock_us;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      apply_item(directed_rows[i].act, directed_rows[i].sq, directed_rows[i].st,
                 directed_rows[i].lt, gap_len(), directed_rows[i].typed, directed_rows[i].ack);

    next_seq = 32'd2;
    clock_us = 32'd1000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick     = $urandom_range(0, 99);
      clock_us = clock_us + $urandom_range(1, 3000);
      if ($urandom_range(0, 49) == 0) clock_us = clock_us + $urandom;
      act = ACT_DATA;
      lt  = clock_us;
      st  = clock_us - $urandom_range(0, 4000);
      if (pick < 20) begin
        act = ACT_TIMER;
        sq  = $urandom;
        st  = $urandom;
      end else if (pick < 24) begin
        // restart of the stream
        sq       = '0;
        next_seq = 32'd1;
      end else if (pick < 28) begin
        sq = next_seq - $urandom_range(1, 3);
      end else if (pick < 36) begin
        next_seq = next_seq + $urandom_range(1, 6);
        sq       = next_seq;
        next_seq = next_seq + 32'd1;
      end else if (pick < 40) begin
        sq = $urandom;
        st = $urandom;
        lt = $urandom;
      end else begin
        sq       = next_seq;
        next_seq = next_seq + 32'd1;
      end
      // send stamp later than local time, delay clamps to zero
      if (act == ACT_DATA && $urandom_range(0, 19) == 0) st = lt + $urandom_range(1, 500);
      apply_item(act, sq, st, lt, ((n / 64) % 3 == 1) ? 0 : gap_len(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_acks.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("loss_feedback_rate_scaler_unit: match");
    else $display("loss_feedback_rate_scaler_unit: mismatch");
    $finish;
  end

endmodule
